>>> rtl/line_pixel_generator_macros.svh
// Assertion macros for the line pixel generator.
// Included by the top level; assertions compile away when SYNTHESIS is defined.
`ifndef LINE_PIXEL_GENERATOR_MACROS_SVH
`define LINE_PIXEL_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define LPG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("line pixel generator: check failed");
// Next-cycle implication, disabled while reset is low.
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("line pixel generator: check failed");
`else
`define LPG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
// No dependencies; used by the interfaces and every module.
package lpg_pkg;

    // Configuration register width and reset values.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] MAX_X_RESET = 11'd639;
    localparam logic [CFG_W-1:0] MAX_Y_RESET = 11'd479;

    // Color word width.
    localparam int COLOR_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_X = 1'b0,
        CFG_MAX_Y = 1'b1
    } t_cfg_idx;

    // Per-word decision flags that travel alongside the divider.
    typedef struct packed {
        logic x_major;
        logic step_ok;
        logic start_ok;
        logic major_ok;
        logic neg;
        logic zero_div;
    } t_flags;

endpackage

>>> rtl/lpg_if.sv
// Valid/ready channel interfaces for line words in and pixel words out.
// Depends on lpg_pkg for the color width.
interface lpg_line_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [COORD_BITS-1:0]        step_index;
    logic [lpg_pkg::COLOR_W-1:0]  pen_color;

    modport source (output valid, x_start, y_start, x_end, y_end, step_index, pen_color,
                    input ready);
    modport sink (input valid, x_start, y_start, x_end, y_end, step_index, pen_color,
                  output ready);
endinterface

interface lpg_pixel_if #(parameter int COORD_BITS = 12);
    logic                        valid;
    logic                        ready;
    logic signed [COORD_BITS:0]  pixel_x;
    logic signed [COORD_BITS:0]  pixel_y;
    logic [lpg_pkg::COLOR_W-1:0] pixel_color;
    logic                        drawn;
    logic                        done_res;

    modport source (output valid, pixel_x, pixel_y, pixel_color, drawn, done_res,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_color, drawn, done_res,
                  output ready);
endinterface

>>> rtl/lpg_setup.sv
// Front end: major axis choice, endpoint ordering and clip pre-checks.
// Three register stages; depends on lpg_pkg.
module lpg_setup #(
    parameter int COORD_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  logic signed [COORD_BITS-1:0]   i_xs,
    input  logic signed [COORD_BITS-1:0]   i_ys,
    input  logic signed [COORD_BITS-1:0]   i_xe,
    input  logic signed [COORD_BITS-1:0]   i_ye,
    input  logic [COORD_BITS-1:0]          i_k,
    input  logic [lpg_pkg::COLOR_W-1:0]    i_color,
    input  logic [lpg_pkg::CFG_W-1:0]      i_max_x,
    input  logic [lpg_pkg::CFG_W-1:0]      i_max_y,
    output logic                           o_valid,
    output lpg_pkg::t_flags                o_flags,
    output logic [COORD_BITS-1:0]          o_dmaj,
    output logic [COORD_BITS-1:0]          o_dmin_abs,
    output logic [COORD_BITS-1:0]          o_k,
    output logic [COORD_BITS:0]            o_major,
    output logic signed [COORD_BITS-1:0]   o_sn,
    output logic [lpg_pkg::COLOR_W-1:0]    o_color
);

    localparam int C  = COORD_BITS;
    localparam int CW = (C + 2 > lpg_pkg::CFG_W + 1) ? C + 2 : lpg_pkg::CFG_W + 1;

    // Stage 1: deltas and major axis selection.
    logic [C:0] w_dx, w_dy, w_adx, w_ady;
    logic       w_x_major;

    assign w_dx      = {i_xe[C-1], i_xe} - {i_xs[C-1], i_xs};
    assign w_dy      = {i_ye[C-1], i_ye} - {i_ys[C-1], i_ys};
    assign w_adx     = w_dx[C] ? (~w_dx + 1'b1) : w_dx;
    assign w_ady     = w_dy[C] ? (~w_dy + 1'b1) : w_dy;
    assign w_x_major = (w_adx >= w_ady);

    logic                 r1_valid, r1_x_major;
    logic signed [C-1:0]  r1_sm, r1_sn, r1_em, r1_en;
    logic [C-1:0]         r1_k;
    logic [lpg_pkg::COLOR_W-1:0] r1_color;

    // Stage 2: order endpoints so the major coordinate rises.
    logic                 w_swap;
    logic signed [C-1:0]  w_sm, w_sn, w_em, w_en;
    logic [C:0]           w_dmaj_full;

    assign w_swap      = (r1_sm > r1_em);
    assign w_sm        = w_swap ? r1_em : r1_sm;
    assign w_em        = w_swap ? r1_sm : r1_em;
    assign w_sn        = w_swap ? r1_en : r1_sn;
    assign w_en        = w_swap ? r1_sn : r1_en;
    assign w_dmaj_full = {w_em[C-1], w_em} - {w_sm[C-1], w_sm};

    logic                 r2_valid, r2_x_major;
    logic signed [C-1:0]  r2_sm, r2_sn;
    logic [C-1:0]         r2_dmaj, r2_k;
    logic [C:0]           r2_dmin;
    logic [lpg_pkg::COLOR_W-1:0] r2_color;

    // Stage 3: major coordinate, clip tests on major and start, magnitude of minor delta.
    logic signed [CW-1:0]          w_major, w_sn_ext, w_max_m_ext, w_max_n_ext;
    logic [lpg_pkg::CFG_W-1:0]     w_max_m, w_max_n;
    logic [C:0]                    w_dmin_abs;
    lpg_pkg::t_flags               w_flags;

    assign w_major     = $signed({{(CW-C){r2_sm[C-1]}}, r2_sm})
                       + $signed({{(CW-C){1'b0}}, r2_k});
    assign w_sn_ext    = $signed({{(CW-C){r2_sn[C-1]}}, r2_sn});
    assign w_max_m     = r2_x_major ? i_max_x : i_max_y;
    assign w_max_n     = r2_x_major ? i_max_y : i_max_x;
    assign w_max_m_ext = $signed({{(CW-lpg_pkg::CFG_W){1'b0}}, w_max_m});
    assign w_max_n_ext = $signed({{(CW-lpg_pkg::CFG_W){1'b0}}, w_max_n});
    assign w_dmin_abs  = r2_dmin[C] ? (~r2_dmin + 1'b1) : r2_dmin;

    always_comb begin
        w_flags          = '0;
        w_flags.x_major  = r2_x_major;
        w_flags.step_ok  = (r2_k < r2_dmaj);
        w_flags.start_ok = (w_sn_ext <= w_max_n_ext);
        w_flags.major_ok = (w_major <= w_max_m_ext);
        w_flags.neg      = r2_dmin[C];
        w_flags.zero_div = (r2_dmaj == '0);
    end

    // Valid bits for the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
    end

    // Payload registers for the three stages.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_x_major <= w_x_major;
            r1_sm      <= w_x_major ? i_xs : i_ys;
            r1_sn      <= w_x_major ? i_ys : i_xs;
            r1_em      <= w_x_major ? i_xe : i_ye;
            r1_en      <= w_x_major ? i_ye : i_xe;
            r1_k       <= i_k;
            r1_color   <= i_color;

            r2_x_major <= r1_x_major;
            r2_sm      <= w_sm;
            r2_sn      <= w_sn;
            r2_dmaj    <= w_dmaj_full[C-1:0];
            r2_dmin    <= {w_en[C-1], w_en} - {w_sn[C-1], w_sn};
            r2_k       <= r1_k;
            r2_color   <= r1_color;

            o_flags    <= w_flags;
            o_dmaj     <= r2_dmaj;
            o_dmin_abs <= w_dmin_abs[C-1:0];
            o_k        <= r2_k;
            o_major    <= w_major[C:0];
            o_sn       <= r2_sn;
            o_color    <= r2_color;
        end
    end

endmodule

>>> rtl/lpg_divider.sv
// Multiply stage and pipelined restoring divider, one quotient bit per stage.
// Carries flags and a side word alongside; depends on lpg_pkg.
module lpg_divider #(
    parameter int COORD_BITS = 12,
    parameter int SIDE_W     = 57
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_valid,
    input  logic [COORD_BITS-1:0]  i_divisor,
    input  logic [COORD_BITS-1:0]  i_a,
    input  logic [COORD_BITS-1:0]  i_b,
    input  lpg_pkg::t_flags        i_flags,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [COORD_BITS-1:0]  o_quot,
    output lpg_pkg::t_flags        o_flags,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int C = COORD_BITS;

    // Dividend is the product; the quotient never exceeds b, so it fits C bits
    // and the upper half of the product is already below the divisor.
    logic [2*C-1:0] w_prod;
    assign w_prod = {{C{1'b0}}, i_a} * {{C{1'b0}}, i_b};

    // Stage s holds partial remainder, remaining dividend bits shifted with
    // quotient bits coming in from the bottom, and the divisor.
    logic [C-1:0]        r_rem [0:C];
    logic [C-1:0]        r_lq  [0:C];
    logic [C-1:0]        r_dv  [0:C];
    logic                r_vld [0:C];
    lpg_pkg::t_flags     r_flg [0:C];
    logic [SIDE_W-1:0]   r_sd  [0:C];

    logic [C:0] w_trial [0:C-1];
    logic [C:0] w_diff  [0:C-1];
    logic       w_qbit  [0:C-1];

    // One trial subtraction per stage.
    always_comb begin
        for (int s = 0; s < C; s++) begin
            w_trial[s] = {r_rem[s], r_lq[s][C-1]};
            w_diff[s]  = w_trial[s] - {1'b0, r_dv[s]};
            w_qbit[s]  = (w_trial[s] >= {1'b0, r_dv[s]});
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= C; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 0; s < C; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    // Product register, then the divider stages.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= w_prod[2*C-1:C];
            r_lq[0]  <= w_prod[C-1:0];
            r_dv[0]  <= i_divisor;
            r_flg[0] <= i_flags;
            r_sd[0]  <= i_side;
            for (int s = 0; s < C; s++) begin
                r_rem[s+1] <= w_qbit[s] ? w_diff[s][C-1:0] : w_trial[s][C-1:0];
                r_lq[s+1]  <= {r_lq[s][C-2:0], w_qbit[s]};
                r_dv[s+1]  <= r_dv[s];
                r_flg[s+1] <= r_flg[s];
                r_sd[s+1]  <= r_sd[s];
            end
        end
    end

    assign o_valid = r_vld[C];
    assign o_quot  = r_lq[C];
    assign o_flags = r_flg[C];
    assign o_side  = r_sd[C];

endmodule

>>> rtl/line_pixel_generator.sv
// Line pixel generator: one pixel of a line per word, fully pipelined.
// Its stages are three setup stages, one multiply stage, one divider stage
// per quotient bit and one output register.
// Throughput is one word per cycle; a stalled output freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and loads the clip
// bounds with 639 and 479.
`include "line_pixel_generator_macros.svh"

module line_pixel_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lpg_line_if.sink                         i_line,
    lpg_pixel_if.source                      o_pixel,
    input  logic                             i_cfg_we,
    input  logic [lpg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lpg_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int C      = COORD_BITS;
    localparam int CW     = (C + 2 > lpg_pkg::CFG_W + 1) ? C + 2 : lpg_pkg::CFG_W + 1;
    localparam int SIDE_W = (C + 1) + C + lpg_pkg::COLOR_W;

    // Clip bound registers.
    logic [lpg_pkg::CFG_W-1:0] r_max_x, r_max_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x <= lpg_pkg::MAX_X_RESET;
            r_max_y <= lpg_pkg::MAX_Y_RESET;
        end else if (i_cfg_we) begin
            unique case (lpg_pkg::t_cfg_idx'(i_cfg_idx))
                lpg_pkg::CFG_MAX_X: r_max_x <= i_cfg_data;
                lpg_pkg::CFG_MAX_Y: r_max_y <= i_cfg_data;
            endcase
        end
    end

    // The pipeline moves whenever the output register is empty or being taken.
    logic r_out_valid;
    logic w_adv;

    assign w_adv        = !r_out_valid || o_pixel.ready;
    assign i_line.ready = w_adv;

    // Front end.
    logic                        s_valid;
    lpg_pkg::t_flags             s_flags;
    logic [C-1:0]                s_dmaj, s_dmin_abs, s_k;
    logic [C:0]                  s_major;
    logic signed [C-1:0]         s_sn;
    logic [lpg_pkg::COLOR_W-1:0] s_color;

    lpg_setup #(.COORD_BITS(C)) u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (i_line.valid),
        .i_xs       (i_line.x_start),
        .i_ys       (i_line.y_start),
        .i_xe       (i_line.x_end),
        .i_ye       (i_line.y_end),
        .i_k        (i_line.step_index),
        .i_color    (i_line.pen_color),
        .i_max_x    (r_max_x),
        .i_max_y    (r_max_y),
        .o_valid    (s_valid),
        .o_flags    (s_flags),
        .o_dmaj     (s_dmaj),
        .o_dmin_abs (s_dmin_abs),
        .o_k        (s_k),
        .o_major    (s_major),
        .o_sn       (s_sn),
        .o_color    (s_color)
    );

    // Minor offset magnitude = |d_minor| * k / d_major.
    logic                        d_valid;
    logic [C-1:0]                d_quot;
    lpg_pkg::t_flags             d_flags;
    logic [SIDE_W-1:0]           d_side;

    lpg_divider #(.COORD_BITS(C), .SIDE_W(SIDE_W)) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (s_valid),
        .i_divisor (s_dmaj),
        .i_a       (s_dmin_abs),
        .i_b       (s_k),
        .i_flags   (s_flags),
        .i_side    ({s_major, s_sn, s_color}),
        .o_valid   (d_valid),
        .o_quot    (d_quot),
        .o_flags   (d_flags),
        .o_side    (d_side)
    );

    // Unpack the side word.
    logic [C:0]                  w_major;
    logic signed [C-1:0]         w_sn;
    logic [lpg_pkg::COLOR_W-1:0] w_color;

    assign w_major = d_side[SIDE_W-1 -: C+1];
    assign w_sn    = d_side[lpg_pkg::COLOR_W +: C];
    assign w_color = d_side[lpg_pkg::COLOR_W-1:0];

    // Minor coordinate with truncation toward zero, then the last clip test.
    logic signed [CW-1:0]      w_sn_ext, w_q_ext, w_minor, w_max_n_ext;
    logic [lpg_pkg::CFG_W-1:0] w_max_n;
    logic                      w_drawn;

    assign w_sn_ext    = $signed({{(CW-C){w_sn[C-1]}}, w_sn});
    assign w_q_ext     = $signed({{(CW-C){1'b0}}, d_quot});
    assign w_max_n     = d_flags.x_major ? r_max_y : r_max_x;
    assign w_max_n_ext = $signed({{(CW-lpg_pkg::CFG_W){1'b0}}, w_max_n});

    always_comb begin
        priority if (d_flags.zero_div) begin
            w_minor = w_sn_ext;
        end else if (d_flags.neg) begin
            w_minor = w_sn_ext - w_q_ext;
        end else begin
            w_minor = w_sn_ext + w_q_ext;
        end
    end

    assign w_drawn = d_flags.step_ok && d_flags.major_ok && d_flags.start_ok
                  && (w_minor <= w_max_n_ext);

    // Output register.
    logic signed [C:0]           r_px, r_py;
    logic [lpg_pkg::COLOR_W-1:0] r_color;
    logic                        r_drawn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px    <= d_flags.x_major ? w_major : w_minor[C:0];
            r_py    <= d_flags.x_major ? w_minor[C:0] : w_major;
            r_color <= w_color;
            r_drawn <= w_drawn;
        end
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_x     = r_px;
    assign o_pixel.pixel_y     = r_py;
    assign o_pixel.pixel_color = r_color;
    assign o_pixel.drawn       = r_drawn;
    assign o_pixel.done_res    = !r_drawn;

    // A pixel word is either drawn or past the exit, never both.
    `LPG_ASSERT_IMPL(a_drawn_done_excl, i_clk, i_rst_n, o_pixel.valid, o_pixel.drawn != o_pixel.done_res)
    // Input back-pressure only comes from a held output word.
    `LPG_ASSERT_IMPL(a_stall_source, i_clk, i_rst_n, !i_line.ready, o_pixel.valid && !o_pixel.ready)
    // A write to the x bound lands in the register on the next cycle.
    `LPG_ASSERT_NEXT(a_cfg_max_x, i_clk, i_rst_n, i_cfg_we && (i_cfg_idx == lpg_pkg::CFG_MAX_X), r_max_x == $past(i_cfg_data))

endmodule
